// File: hdl/hta_pkg.sv
// Package with request codes, widths and defaults for the handle table allocator.
package hta_pkg;
	localparam int unsigned DefCapacity = 1024;
	localparam int unsigned IdxW = 16;
	localparam int unsigned ObjW = 30;
	localparam int unsigned WordW = 32;

	typedef enum logic [2:0] {
		REQ_ADD    = 3'd0,
		REQ_REMOVE = 3'd1,
		REQ_LOOKUP = 3'd2,
		REQ_SETFLG = 3'd3,
		REQ_SEARCH = 3'd4,
		REQ_CLEAR  = 3'd5
	} req_t;

	typedef struct packed {
		logic             start;
		logic             want_used;
		logic [IdxW-1:0]  from;
		logic [IdxW:0]    limit;
	} scan_cmd_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [IdxW-1:0]  pos;
	} scan_rsp_t;
endpackage

// File: hdl/handle_table_allocator.sv
// Top level of the handle table allocator.
// Add and search scan the in-use bitmap one 32-slot word at a time; add scans the
// bitmap a second time when the table grows.
// Only one request is handled at a time, and a clear sweeps the whole bitmap.
// After reset the bitmap is swept clear while in_ready is low.
module handle_table_allocator import hta_pkg::*; #(
	parameter int unsigned CAPACITY = DefCapacity
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       req_type,
	input  logic [IdxW-1:0]  slot_index,
	input  logic [ObjW-1:0]  object_word,
	input  logic             flag_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             status,
	output logic [IdxW-1:0]  result_index,
	output logic [ObjW-1:0]  object_out,
	output logic             flag_out
);
	scan_cmd_t       scmd;
	scan_rsp_t       srsp;
	logic            wr_en, wr_val, rd_en, rd_bit, clr_start, clr_busy;
	logic [IdxW-1:0] wr_pos, rd_pos;

	hta_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .slot_index, .object_word,
		.flag_value, .out_valid, .out_ready, .status, .result_index, .object_out,
		.flag_out, .scmd, .srsp, .bm_wr_en(wr_en), .bm_wr_pos(wr_pos),
		.bm_wr_val(wr_val), .bm_rd_en(rd_en), .bm_rd_pos(rd_pos), .bm_rd_bit(rd_bit),
		.clr_start, .clr_busy
	);

	hta_bitmap #(.CAPACITY(CAPACITY)) u_bitmap (
		.clk, .arst_n, .cmd(scmd), .rsp(srsp), .wr_en, .wr_pos, .wr_val,
		.rd_en, .rd_pos, .rd_bit, .clr_start, .clr_busy
	);
endmodule

// File: hdl/hta_bitmap.sv
// In-use bitmap held as 32-bit words, with a word-at-a-time scanner for the first match.
module hta_bitmap import hta_pkg::*; #(
	parameter int unsigned CAPACITY = DefCapacity
) (
	input  logic                clk,
	input  logic                arst_n,
	input  scan_cmd_t           cmd,
	output scan_rsp_t           rsp,
	input  logic                wr_en,
	input  logic [IdxW-1:0]     wr_pos,
	input  logic                wr_val,
	input  logic                rd_en,
	input  logic [IdxW-1:0]     rd_pos,
	output logic                rd_bit,
	input  logic                clr_start,
	output logic                clr_busy
);
	localparam int unsigned NWords = (CAPACITY + WordW - 1) / WordW;
	localparam int unsigned WaW = (NWords > 1) ? $clog2(NWords) : 1;

	logic [WordW-1:0] mem [NWords];
	logic [WordW-1:0] rdata_q;
	logic [4:0]       rbit_q;

	typedef enum logic [1:0] {S_IDLE, S_READ, S_TEST, S_CLR} st_t;
	st_t             st_q;
	logic [IdxW-1:0] base_q;
	logic [4:0]      off_q;
	logic            want_q;
	logic [IdxW:0]   lim_q;
	logic [WaW-1:0]  clr_q;
	scan_rsp_t       rsp_q;

	logic [WaW-1:0]  raddr;
	logic [WordW-1:0] hit;
	logic             any;
	logic [4:0]       first;
	logic [IdxW:0]    fpos;
	logic [IdxW:0]    next_base;

	assign raddr = rd_en ? rd_pos[WaW+4:5] : base_q[WaW+4:5];

	// Bits at or above the offset that match the wanted value.
	always_comb begin
		for (int i = 0; i < WordW; i++) begin
			hit[i] = ((rdata_q[i] == want_q) && (i[4:0] >= off_q));
		end
		any = |hit;
		first = '0;
		for (int i = WordW - 1; i >= 0; i--) begin
			if (hit[i]) first = i[4:0];
		end
		fpos = {1'b0, base_q[IdxW-1:5], first};
		next_base = {1'b0, base_q[IdxW-1:5], 5'd0} + (IdxW+1)'(WordW);
	end

	always_ff @(posedge clk) begin
		if (st_q == S_CLR) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_pos[WaW+4:5]][wr_pos[4:0]] <= wr_val;
		end
		rdata_q <= mem[raddr];
		rbit_q  <= rd_pos[4:0];
	end

	assign rd_bit = rdata_q[rbit_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_CLR;
			base_q <= '0;
			off_q  <= '0;
			want_q <= 1'b0;
			lim_q  <= '0;
			clr_q  <= '0;
			rsp_q  <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (clr_start) begin
						clr_q <= '0;
						st_q  <= S_CLR;
					end else if (cmd.start) begin
						want_q <= cmd.want_used;
						lim_q  <= cmd.limit;
						base_q <= cmd.from;
						off_q  <= cmd.from[4:0];
						if ({1'b0, cmd.from} >= cmd.limit) begin
							rsp_q <= '{done: 1'b1, found: 1'b0, pos: '0};
						end else begin
							st_q <= S_READ;
						end
					end
				end
				S_READ: st_q <= S_TEST;
				S_TEST: begin
					if (any && fpos < lim_q) begin
						rsp_q <= '{done: 1'b1, found: 1'b1, pos: fpos[IdxW-1:0]};
						st_q  <= S_IDLE;
					end else if (any || next_base >= lim_q) begin
						rsp_q <= '{done: 1'b1, found: 1'b0, pos: '0};
						st_q  <= S_IDLE;
					end else begin
						base_q <= next_base[IdxW-1:0];
						off_q  <= '0;
						st_q   <= S_READ;
					end
				end
				S_CLR: begin
					if (clr_q == WaW'(NWords - 1)) st_q <= S_IDLE;
					else clr_q <= clr_q + 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp = rsp_q;
	assign clr_busy = (st_q == S_CLR);

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_q.done && rsp_q.found) |-> ({1'b0, rsp_q.pos} < lim_q))
		else $error("scan hit beyond limit");
	a_one_cycle_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_q.done |=> !rsp_q.done)
		else $error("scan done held");
	a_clr_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_CLR) |-> !rsp_q.done)
		else $error("scan done during clear");
endmodule

// File: hdl/hta_ctrl.sv
// Request sequencer: sizing, entry store and result register.
module hta_ctrl import hta_pkg::*; #(
	parameter int unsigned CAPACITY = DefCapacity
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       req_type,
	input  logic [IdxW-1:0]  slot_index,
	input  logic [ObjW-1:0]  object_word,
	input  logic             flag_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             status,
	output logic [IdxW-1:0]  result_index,
	output logic [ObjW-1:0]  object_out,
	output logic             flag_out,
	output scan_cmd_t        scmd,
	input  scan_rsp_t        srsp,
	output logic             bm_wr_en,
	output logic [IdxW-1:0]  bm_wr_pos,
	output logic             bm_wr_val,
	output logic             bm_rd_en,
	output logic [IdxW-1:0]  bm_rd_pos,
	input  logic             bm_rd_bit,
	output logic             clr_start,
	input  logic             clr_busy
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [IdxW:0] Cap = (IdxW+1)'(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SCANW, S_GROW, S_RESCAN, S_WRITE,
		S_RD0, S_RD1, S_ACT, S_SRD, S_CLRW, S_OUT
	} st_t;
	st_t st_q;

	logic [2:0]      req_q;
	logic [IdxW-1:0] idx_q;
	logic [ObjW-1:0] obj_q;
	logic            flg_q;
	logic [IdxW:0]   size_q;
	logic [IdxW-1:0] free_q;
	logic            retried_q;
	logic [IdxW-1:0] pos_q;

	logic [ObjW:0]   store [CAPACITY];
	logic [ObjW:0]   sdata_q;
	logic            st_we;
	logic [AW-1:0]   st_wa;
	logic [ObjW:0]   st_wd;
	logic [AW-1:0]   st_ra;

	logic [IdxW:0]   grow;
	logic [IdxW:0]   ns;
	logic            idx_ok;

	always_comb begin
		if ({1'b0, idx_q} >= size_q) grow = {1'b0, idx_q} + 1'b1;
		else grow = size_q + ((size_q + (IdxW+1)'(4)) >> 2);
		ns = grow;
		if (ns < (IdxW+1)'(8)) ns = (IdxW+1)'(8);
		if (ns > Cap) ns = Cap;
		idx_ok = ({1'b0, idx_q} < size_q);
	end

	// The slot found by a search is read in the cycle after the scan reports it.
	assign st_ra = (st_q == S_SRD) ? pos_q[AW-1:0] : idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (st_we) store[st_wa] <= st_wd;
		sdata_q <= store[st_ra];
	end

	always_comb begin
		st_we = 1'b0;
		st_wa = pos_q[AW-1:0];
		st_wd = {1'b0, obj_q};
		if (st_q == S_WRITE) st_we = 1'b1;
		if (st_q == S_ACT && req_q == REQ_SETFLG && idx_ok && bm_rd_bit) begin
			st_we = 1'b1;
			st_wa = idx_q[AW-1:0];
			st_wd = {flg_q, sdata_q[ObjW-1:0]};
		end
	end

	always_comb begin
		scmd = '{start: 1'b0, want_used: 1'b0, from: idx_q, limit: size_q};
		if (st_q == S_SCAN || st_q == S_GROW) scmd.start = 1'b1;
		if (st_q == S_GROW) scmd.limit = ns;
		if (st_q == S_SCAN && req_q == REQ_SEARCH) scmd.want_used = 1'b1;
		bm_wr_en  = (st_q == S_WRITE) ||
			(st_q == S_ACT && req_q == REQ_REMOVE && idx_ok && bm_rd_bit);
		bm_wr_pos = (st_q == S_WRITE) ? pos_q : idx_q;
		bm_wr_val = (st_q == S_WRITE);
		bm_rd_en  = (st_q == S_RD0) || (st_q == S_RD1);
		bm_rd_pos = idx_q;
		clr_start = (st_q == S_CLRW) && !clr_busy && (req_q == REQ_CLEAR)
			&& !retried_q;
	end

	assign in_ready = (st_q == S_IDLE) && !clr_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			size_q    <= '0;
			free_q    <= '0;
			out_valid <= 1'b0;
			retried_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						req_q        <= req_type;
						idx_q        <= slot_index;
						obj_q        <= object_word;
						flg_q        <= flag_value;
						retried_q    <= 1'b0;
						status       <= 1'b1;
						result_index <= '0;
						object_out   <= '0;
						flag_out     <= 1'b0;
						unique case (req_type)
							REQ_ADD, REQ_SEARCH: st_q <= S_SCAN;
							REQ_REMOVE, REQ_LOOKUP, REQ_SETFLG: st_q <= S_RD0;
							REQ_CLEAR: st_q <= S_CLRW;
							default: st_q <= S_OUT;
						endcase
					end
				end
				S_SCAN: st_q <= S_SCANW;
				S_SCANW: begin
					if (srsp.done) begin
						pos_q <= srsp.pos;
						if (srsp.found && req_q == REQ_SEARCH) begin
							st_q <= S_SRD;
						end else if (srsp.found) begin
							st_q <= S_WRITE;
						end else if (req_q == REQ_ADD && size_q < Cap && !retried_q) begin
							st_q <= S_GROW;
						end else begin
							st_q <= S_OUT;
						end
					end
				end
				S_GROW: begin
					free_q    <= free_q + IdxW'(ns - size_q);
					size_q    <= ns;
					retried_q <= 1'b1;
					st_q      <= S_SCANW;
				end
				S_WRITE: begin
					free_q       <= free_q - 1'b1;
					status       <= 1'b0;
					result_index <= pos_q;
					st_q         <= S_OUT;
				end
				S_SRD: st_q <= S_RESCAN;
				S_RESCAN: begin
					status       <= 1'b0;
					result_index <= pos_q;
					object_out   <= sdata_q[ObjW-1:0];
					st_q         <= S_OUT;
				end
				S_RD0: st_q <= S_RD1;
				S_RD1: st_q <= S_ACT;
				S_ACT: begin
					if (idx_ok && bm_rd_bit) begin
						status <= 1'b0;
						if (req_q == REQ_REMOVE) begin
							object_out <= sdata_q[ObjW-1:0];
							free_q     <= free_q + 1'b1;
						end
						if (req_q == REQ_LOOKUP) begin
							object_out <= sdata_q[ObjW-1:0];
							flag_out   <= sdata_q[ObjW];
						end
					end
					st_q <= S_OUT;
				end
				S_CLRW: begin
					// The bitmap sweep starts here; the result waits for it to finish.
					if (!retried_q) begin
						retried_q <= 1'b1;
						size_q    <= '0;
						free_q    <= '0;
					end else if (!clr_busy) begin
						status <= 1'b0;
						st_q   <= S_OUT;
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						st_q      <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_size_cap: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= Cap) else $error("size beyond capacity");
	a_free_le_size: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, free_q} <= size_q) else $error("free count beyond size");
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (st_q == S_OUT)) else $error("result outside output state");
endmodule
